// File: src/poly5_pkg.sv
// ----------------------------------------------------------------------------
// poly5_pkg: shared constants and types
// Widths, register indexes and control structures for the five-variable
// polynomial evaluator.
// ----------------------------------------------------------------------------
package poly5_pkg;

    localparam int MAX_ORDER_DEF = 4;
    localparam int NUM_CAPS      = 5;
    localparam int CAP_W         = 3;
    localparam int COEF_W        = 32;
    localparam int X_W           = 18;
    localparam int MONO_W        = 24;
    localparam int ACC_W         = 40;
    localparam int IDX_W         = 7;

    localparam logic [CAP_W-1:0] CAP_RST = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_CAP_XF  = 3'd0;
    localparam logic [2:0] REG_CAP_XPF = 3'd1;
    localparam logic [2:0] REG_CAP_YF  = 3'd2;
    localparam logic [2:0] REG_CAP_YPF = 3'd3;
    localparam logic [2:0] REG_CAP_ZT  = 3'd4;

    // Item kinds carried on the input tuser.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef logic [NUM_CAPS-1:0][CAP_W-1:0] t_caps;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_x;
        logic       mono_init;
        logic       mono_mul;
        logic [2:0] mono_sel;
        logic       rd_en;
        logic       coef_mul;
        logic       acc_add;
        logic       res_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic res_free;
    } t_stat;

    // Number of terms of total order up to the given order in five variables.
    function automatic int coef_depth(input int order);
        return (order + 1) * (order + 2) * (order + 3) * (order + 4) * (order + 5) / 120;
    endfunction

endpackage

// File: src/poly5_ram.sv
// ----------------------------------------------------------------------------
// poly5_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module poly5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 126
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/poly5_dp.sv
// ----------------------------------------------------------------------------
// poly5_dp: evaluator datapath
// Coefficient store, monomial multiplier, term multiplier, saturating
// accumulator and the result register.
// ----------------------------------------------------------------------------
module poly5_dp
    import poly5_pkg::*;
#(
    parameter int DEPTH = coef_depth(MAX_ORDER_DEF)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic signed [COEF_W-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    input  logic signed [X_W-1:0]    i_x [NUM_CAPS],
    input  logic                     i_m_tready,
    output logic                     o_m_tvalid,
    output logic signed [ACC_W-1:0]  o_value,
    output logic                     o_sat
);

    logic signed [X_W-1:0]          r_x [NUM_CAPS];
    logic signed [MONO_W-1:0]       r_mono;
    logic signed [COEF_W+MONO_W-1:0] r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic                           r_sat;
    logic signed [ACC_W-1:0]        r_res;
    logic                           r_rsat;
    logic                           r_ovalid;

    logic signed [COEF_W-1:0]       w_coef;
    logic signed [X_W-1:0]          w_x;
    logic signed [MONO_W+X_W-1:0]   w_mp;
    logic signed [MONO_W+X_W:0]     w_mr;
    logic signed [MONO_W+X_W-16:0]  w_mq;
    logic signed [MONO_W-1:0]       n_mono;
    logic                           w_mclip;
    logic signed [COEF_W+MONO_W:0]  w_tr;
    logic signed [ACC_W:0]          w_t;
    logic signed [ACC_W+1:0]        w_sum;
    logic signed [ACC_W-1:0]        n_acc;
    logic                           w_aclip;

    poly5_ram #(
        .WIDTH (COEF_W),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_raddr),
        .o_rdata (w_coef)
    );

    assign w_x  = r_x[i_cmd.mono_sel];
    assign w_mp = r_mono * w_x;
    assign w_mr = (MONO_W+X_W+1)'(w_mp) + (MONO_W+X_W+1)'(32768);
    assign w_mq = w_mr[MONO_W+X_W:16];

    // Monomial rounding result saturated to the signed Q8.16 range.
    always_comb begin
        w_mclip = 1'b1;
        if (w_mq > (MONO_W+X_W-15)'(8388607)) begin
            n_mono = MONO_W'(8388607);
        end else if (w_mq < -(MONO_W+X_W-15)'(8388608)) begin
            n_mono = MONO_W'(-8388608);
        end else begin
            n_mono  = MONO_W'(w_mq);
            w_mclip = 1'b0;
        end
    end

    assign w_tr  = (COEF_W+MONO_W+1)'(r_prod) + (COEF_W+MONO_W+1)'(32768);
    assign w_t   = w_tr[COEF_W+MONO_W:16];
    assign w_sum = (ACC_W+2)'(r_acc) + (ACC_W+2)'(w_t);

    always_comb begin
        w_aclip = 1'b1;
        if (w_sum > (ACC_W+2)'(64'sd549755813887)) begin
            n_acc = ACC_W'(64'sd549755813887);
        end else if (w_sum < -(ACC_W+2)'(64'sd549755813888)) begin
            n_acc = ACC_W'(-64'sd549755813888);
        end else begin
            n_acc   = ACC_W'(w_sum);
            w_aclip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x   <= i_x;
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= n_acc;
        end
        if (i_cmd.mono_init) begin
            r_mono <= MONO_W'(65536);
        end else if (i_cmd.mono_mul) begin
            r_mono <= n_mono;
        end
        if (i_cmd.coef_mul) begin
            r_prod <= w_coef * r_mono;
        end
        if (i_cmd.res_load) begin
            r_res  <= r_acc;
            r_rsat <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load_x) begin
                r_sat <= 1'b0;
            end else if ((i_cmd.mono_mul && w_mclip) || (i_cmd.acc_add && w_aclip)) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.res_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.res_free = !r_ovalid || i_m_tready;
    assign o_m_tvalid      = r_ovalid;
    assign o_value         = r_res;
    assign o_sat           = r_rsat;

endmodule

// File: src/poly5_ctrl.sv
// ----------------------------------------------------------------------------
// poly5_ctrl: evaluator controller
// Walks the exponent tuples in coefficient order and sequences the
// monomial, term and accumulate steps of the datapath.
// ----------------------------------------------------------------------------
module poly5_ctrl
    import poly5_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int DEPTH     = coef_depth(MAX_ORDER_DEF)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_caps                    i_caps,
    input  logic                     i_accept,
    input  logic                     i_func,
    output logic                     o_ready,
    output t_cmd                     o_cmd,
    input  t_stat                    i_stat,
    output logic [$clog2(DEPTH)-1:0] o_raddr
);

    localparam int AW = $clog2(DEPTH);
    localparam int EW = (MAX_ORDER < 2) ? 1 : $clog2(MAX_ORDER + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TERM = 3'd1;
    localparam logic [2:0] S_MONO = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [EW-1:0]       r_n, r_e, r_d, r_c, r_b;
    logic [EW-1:0]       n_n, n_e, n_d, n_c, n_b;
    logic [AW-1:0]       r_idx, n_idx;
    logic [EW-1:0]       r_rem [NUM_CAPS];
    logic [EW-1:0]       n_rem [NUM_CAPS];
    logic [EW-1:0]       w_a;
    logic                w_take;
    logic                w_last;
    logic                w_adv;

    assign w_a = EW'(32'(r_n) - (32'(r_e) + 32'(r_d) + 32'(r_c) + 32'(r_b)));

    assign w_take = (32'(w_a) <= 32'(i_caps[0])) && (32'(r_b) <= 32'(i_caps[1]))
                 && (32'(r_c) <= 32'(i_caps[2])) && (32'(r_d) <= 32'(i_caps[3]))
                 && (32'(r_e) <= 32'(i_caps[4])) && (32'(r_idx) < DEPTH);

    // At MAX_ORDER, the tuple with every exponent on the last variable closes the walk.
    assign w_last = (32'(r_n) == MAX_ORDER) && (r_e == r_n);

    assign o_ready = (r_state == S_IDLE);
    assign o_raddr = r_idx;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_e     = r_e;
        n_d     = r_d;
        n_c     = r_c;
        n_b     = r_b;
        n_idx   = r_idx;
        n_rem   = r_rem;
        o_cmd   = '0;
        w_adv   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_accept && (i_func == FUNC_EVAL)) begin
                    o_cmd.load_x = 1'b1;
                    n_n     = '0;
                    n_e     = '0;
                    n_d     = '0;
                    n_c     = '0;
                    n_b     = '0;
                    n_idx   = '0;
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                if (w_take) begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.mono_init = 1'b1;
                    n_rem[0] = w_a;
                    n_rem[1] = r_b;
                    n_rem[2] = r_c;
                    n_rem[3] = r_d;
                    n_rem[4] = r_e;
                    n_state  = S_MONO;
                end else begin
                    w_adv = 1'b1;
                end
            end
            S_MONO: begin
                o_cmd.mono_mul = 1'b1;
                if (r_rem[0] != '0) begin
                    o_cmd.mono_sel = 3'd0;
                    n_rem[0] = r_rem[0] - 1'b1;
                end else if (r_rem[1] != '0) begin
                    o_cmd.mono_sel = 3'd1;
                    n_rem[1] = r_rem[1] - 1'b1;
                end else if (r_rem[2] != '0) begin
                    o_cmd.mono_sel = 3'd2;
                    n_rem[2] = r_rem[2] - 1'b1;
                end else if (r_rem[3] != '0) begin
                    o_cmd.mono_sel = 3'd3;
                    n_rem[3] = r_rem[3] - 1'b1;
                end else if (r_rem[4] != '0) begin
                    o_cmd.mono_sel = 3'd4;
                    n_rem[4] = r_rem[4] - 1'b1;
                end else begin
                    o_cmd.mono_mul = 1'b0;
                    o_cmd.coef_mul = 1'b1;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                w_adv = 1'b1;
            end
            S_FIN: begin
                if (i_stat.res_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Step to the next tuple: b counts fastest, a takes what is left.
        if (w_adv) begin
            n_idx = r_idx + 1'b1;
            if (w_last) begin
                n_state = S_FIN;
            end else begin
                n_state = S_TERM;
                if ((32'(r_e) + 32'(r_d) + 32'(r_c) + 32'(r_b)) < 32'(r_n)) begin
                    n_b = r_b + 1'b1;
                end else if ((32'(r_e) + 32'(r_d) + 32'(r_c)) < 32'(r_n)) begin
                    n_b = '0;
                    n_c = r_c + 1'b1;
                end else if ((32'(r_e) + 32'(r_d)) < 32'(r_n)) begin
                    n_b = '0;
                    n_c = '0;
                    n_d = r_d + 1'b1;
                end else if (r_e < r_n) begin
                    n_b = '0;
                    n_c = '0;
                    n_d = '0;
                    n_e = r_e + 1'b1;
                end else begin
                    n_b = '0;
                    n_c = '0;
                    n_d = '0;
                    n_e = '0;
                    n_n = r_n + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_e   <= n_e;
        r_d   <= n_d;
        r_c   <= n_c;
        r_b   <= n_b;
        r_idx <= n_idx;
        r_rem <= n_rem;
    end

endmodule

// File: src/poly5_optics_matrix_eval.sv
// ----------------------------------------------------------------------------
// poly5_optics_matrix_eval: five-variable polynomial evaluator
// Stores a coefficient table and evaluates sum of coefficient times monomial
// over the terms up to MAX_ORDER inside the exponent caps, in fixed point, with saturation.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  --------  ---------  -------------------------------------------------------
//  s stream  in         tuser: func; tdata: coef_index, coef_value, pos_x,
//                       ang_x, pos_y, ang_y, target_z
//  m stream  out        tdata: poly_value; tuser: saturated
//  APB       in/out     five 3-bit exponent caps at byte addresses 0 to 16
//
// A load transaction gives no result. An evaluate transaction walks every
// term up to MAX_ORDER; for a term inside the caps it builds the monomial on
// the single monomial multiplier, which is shared over all exponent steps,
// one multiply per cycle, then multiplies by the coefficient and accumulates.
// Reset is synchronous and active low; it clears control state and sets every
// cap to four. The coefficient table is not cleared. A finished result waits
// in the output register while the next transaction is taken; only when a
// second result is ready before the first is taken does the block hold.
// ----------------------------------------------------------------------------
module poly5_optics_matrix_eval
    import poly5_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input stream
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [135:0]  i_s_tdata,   // coef_index[6:0], coef_value[38:7], pos_x[56:39],
                                       // ang_x[74:57], pos_y[92:75], ang_y[110:93],
                                       // target_z[128:111], zero padding[135:129]
    input  logic          i_s_tuser,   // func[0]
    // Output stream
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [39:0]   o_m_tdata,   // poly_value[39:0]
    output logic          o_m_tuser,   // saturated[0]
    // Configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int DEPTH = coef_depth(MAX_ORDER);
    localparam int AW    = $clog2(DEPTH);

    t_caps                   r_caps;
    t_cmd                    w_cmd;
    t_stat                   w_stat;
    logic                    w_accept;
    logic                    w_we;
    logic [AW-1:0]           w_raddr;
    logic [IDX_W-1:0]        w_idx;
    logic signed [X_W-1:0]   w_x [NUM_CAPS];
    logic signed [ACC_W-1:0] w_value;
    logic [2:0]              w_reg;

    // Field unpacking of the input transaction.
    assign w_idx = i_s_tdata[6:0];
    assign w_x[0] = i_s_tdata[56:39];
    assign w_x[1] = i_s_tdata[74:57];
    assign w_x[2] = i_s_tdata[92:75];
    assign w_x[3] = i_s_tdata[110:93];
    assign w_x[4] = i_s_tdata[128:111];

    assign w_accept = i_s_tvalid && o_s_tready;

    // Loads beyond the table are dropped.
    assign w_we = w_accept && (i_s_tuser == FUNC_LOAD) && (32'(w_idx) < DEPTH);

    // Configuration registers. Any value 0..7 is kept as written.
    assign pready = 1'b1;
    assign w_reg  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caps <= {NUM_CAPS{CAP_RST}};
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg)
                REG_CAP_XF:  r_caps[0] <= pwdata[CAP_W-1:0];
                REG_CAP_XPF: r_caps[1] <= pwdata[CAP_W-1:0];
                REG_CAP_YF:  r_caps[2] <= pwdata[CAP_W-1:0];
                REG_CAP_YPF: r_caps[3] <= pwdata[CAP_W-1:0];
                REG_CAP_ZT:  r_caps[4] <= pwdata[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_CAP_XF:  prdata = 32'(r_caps[0]);
            REG_CAP_XPF: prdata = 32'(r_caps[1]);
            REG_CAP_YF:  prdata = 32'(r_caps[2]);
            REG_CAP_YPF: prdata = 32'(r_caps[3]);
            REG_CAP_ZT:  prdata = 32'(r_caps[4]);
            default:     prdata = '0;
        endcase
    end

    poly5_ctrl #(
        .MAX_ORDER (MAX_ORDER),
        .DEPTH     (DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_caps   (r_caps),
        .i_accept (w_accept),
        .i_func   (i_s_tuser),
        .o_ready  (o_s_tready),
        .o_cmd    (w_cmd),
        .i_stat   (w_stat),
        .o_raddr  (w_raddr)
    );

    poly5_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_we       (w_we),
        .i_waddr    (AW'(w_idx)),
        .i_wdata    (i_s_tdata[38:7]),
        .i_raddr    (w_raddr),
        .i_x        (w_x),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_value    (w_value),
        .o_sat      (o_m_tuser)
    );

    assign o_m_tdata = w_value;

endmodule

// File: src/poly5_chk.sv
// ----------------------------------------------------------------------------
// poly5_chk: port checker for the polynomial evaluator
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module poly5_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        pready
);

    // A waiting result keeps its value until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A load transaction never produces a result.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tuser && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("result after a load");

    // The evaluator is busy right after taking an evaluate transaction.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser) |=> !o_s_tready)
        else $error("ready during evaluation");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("configuration port not ready");

endmodule

bind poly5_optics_matrix_eval poly5_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .pready     (pready)
);

// File: dv/poly5_optics_matrix_eval_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly5_optics_matrix_eval_checker: result predictor and scoreboard
// Keeps its own coefficient table and exponent caps. It follows the APB
// writes and the accepted input transactions, predicts each polynomial value,
// and compares every output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module poly5_optics_matrix_eval_checker
    import poly5_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tready,
    input  logic [135:0]  i_s_tdata,   // coef_index, coef_value, pos_x, ang_x, pos_y,
                                       // ang_y, target_z, zero padding
    input  logic          i_s_tuser,   // func
    input  logic          i_m_tvalid,
    input  logic          i_m_tready,
    input  logic [39:0]   i_m_tdata,   // poly_value
    input  logic          i_m_tuser,   // saturated
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [4:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    input  logic          i_pready,
    output int            o_errors,
    output int            o_pending,
    output int            o_results,
    output int            o_saturations
);

    localparam int DEPTH = coef_depth(MAX_ORDER_DEF);
    localparam longint MONO_HI = 64'sd8388607;
    localparam longint MONO_LO = -64'sd8388608;
    localparam longint ACC_HI  = 64'sd549755813887;
    localparam longint ACC_LO  = -64'sd549755813888;

    typedef struct {
        logic [ACC_W-1:0] value;
        logic             sat;
    } t_poly_result;

    logic signed [COEF_W-1:0] coef_mirror [DEPTH];
    logic [CAP_W-1:0]         cap_mirror  [NUM_CAPS];
    t_poly_result             poly_expected [$];

    function automatic longint round16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                     inout logic sat);
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic t_poly_result eval_poly(input logic [135:0] d);
        longint       x [NUM_CAPS];
        int           ex [NUM_CAPS];
        longint       mono;
        longint       acc;
        logic         sat;
        int           idx;
        t_poly_result r;
        acc = 0;
        sat = 1'b0;
        idx = 0;
        for (int k = 0; k < NUM_CAPS; k++) begin
            x[k] = longint'($signed(d[39 + 18*k +: 18]));
        end
        for (int n = 0; n <= MAX_ORDER_DEF; n++) begin
            for (int e = 0; e <= n; e++) begin
                for (int dd = 0; dd <= n; dd++) begin
                    for (int c = 0; c <= n; c++) begin
                        for (int b = 0; b <= n; b++) begin
                            for (int a = 0; a <= n; a++) begin
                                if (a + b + c + dd + e == n) begin
                                    ex[0] = a; ex[1] = b; ex[2] = c; ex[3] = dd; ex[4] = e;
                                    if (idx < DEPTH && a <= cap_mirror[0] &&
                                        b <= cap_mirror[1] && c <= cap_mirror[2] &&
                                        dd <= cap_mirror[3] && e <= cap_mirror[4]) begin
                                        mono = 65536;
                                        for (int k = 0; k < NUM_CAPS; k++) begin
                                            for (int s = 0; s < ex[k]; s++) begin
                                                mono = clamp(round16(mono * x[k]),
                                                             MONO_LO, MONO_HI, sat);
                                            end
                                        end
                                        acc = clamp(acc + round16(
                                                  longint'(coef_mirror[idx]) * mono),
                                                  ACC_LO, ACC_HI, sat);
                                    end
                                    idx++;
                                end
                            end
                        end
                    end
                end
            end
        end
        r.value = acc[ACC_W-1:0];
        r.sat   = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t checker: %s mismatch, got %h expected %h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors      = 0;
        o_results     = 0;
        o_saturations = 0;
        foreach (coef_mirror[i]) coef_mirror[i] = '0;
    end

    assign o_pending = poly_expected.size();

    always @(posedge i_clk) begin
        t_poly_result got;
        t_poly_result want;
        if (!i_rst_n) begin
            foreach (cap_mirror[i]) cap_mirror[i] = CAP_RST;
            poly_expected.delete();
        end else begin
            // Output is checked before the input so that both use the state
            // as it stood before this edge.
            if (i_m_tvalid && i_m_tready) begin
                got.value = i_m_tdata;
                got.sat   = i_m_tuser;
                if (poly_expected.size() == 0) begin
                    $display("%0t checker: output transaction with nothing expected",
                             $realtime);
                    o_errors++;
                end else begin
                    want = poly_expected.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("poly_value", got.value, want.value);
                    if (got.sat !== want.sat)
                        report_mismatch("saturated", got.sat, want.sat);
                    o_results++;
                    if (want.sat) o_saturations++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == FUNC_EVAL) begin
                    poly_expected.push_back(eval_poly(i_s_tdata));
                end else if (i_s_tdata[6:0] < DEPTH) begin
                    coef_mirror[i_s_tdata[6:0]] = i_s_tdata[38:7];
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[4:2] < NUM_CAPS)
                cap_mirror[i_paddr[4:2]] = i_pwdata[CAP_W-1:0];
        end
    end

endmodule

// File: dv/poly5_optics_matrix_eval_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly5_optics_matrix_eval_test: testbench top for the polynomial evaluator
// Fills the coefficient table, runs directed evaluations at the field
// extremes and into saturation, then random load and evaluate traffic under
// several cap settings and idling patterns. A separate checker predicts and
// compares; this module only drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module poly5_optics_matrix_eval_test;
    import poly5_pkg::*;

    localparam int DEPTH = coef_depth(MAX_ORDER_DEF);
    localparam logic signed [17:0] X_MAX = 18'sh1ffff;
    localparam logic signed [17:0] X_MIN = 18'sh20000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_tvalid;
    logic          o_s_tready;
    logic [135:0]  i_s_tdata;   // coef_index, coef_value, pos_x, ang_x, pos_y, ang_y,
                                // target_z, zero padding
    logic          i_s_tuser;   // func
    logic          o_m_tvalid;
    logic          i_m_tready;
    logic [39:0]   o_m_tdata;   // poly_value
    logic          o_m_tuser;   // saturated
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [4:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    int            errors;
    int            pending;
    int            results;
    int            saturations;
    int            sender_idle_pct;
    int            receiver_idle_pct;
    logic          hold_off;
    logic          hold_req;
    int            loads_sent;
    int            evals_sent;

    poly5_optics_matrix_eval u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    poly5_optics_matrix_eval_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tuser     (o_m_tuser),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_results     (results),
        .o_saturations (saturations)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // This limit leaves ample room even for a slow run of a few hundred
    // evaluations at full caps.
    initial begin
        #4000000;
        $display("poly5_optics_matrix_eval_test: errors");
        $finish;
    end

    // The receiver accepts at random according to the current idle share,
    // unless a long hold-off is in progress.
    always @(posedge i_clk) begin
        i_m_tready <= !hold_off && ($urandom_range(99) >= receiver_idle_pct);
    end

    // The long hold-off is timed in its own process, so that the sender keeps
    // offering transactions while the output stays blocked.
    initial begin
        hold_off <= 1'b0;
        @(posedge hold_req);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (4000) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Offers one input transaction and returns at the edge where it is taken.
    // A random gap before it drops tvalid first, so that the next transaction
    // never lowers and raises tvalid within one time step.
    task automatic send_item(input logic func, input logic [6:0] idx,
                             input logic [31:0] coef, input logic [17:0] px,
                             input logic [17:0] ax, input logic [17:0] py,
                             input logic [17:0] ay, input logic [17:0] tz);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {7'd0, tz, ay, py, ax, px, coef, idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (func == FUNC_EVAL) evals_sent++;
        else loads_sent++;
    endtask

    task automatic load_coef(input logic [6:0] idx, input logic [31:0] coef);
        send_item(FUNC_LOAD, idx, coef, 18'($urandom), 18'($urandom), 18'($urandom),
                  18'($urandom), 18'($urandom));
    endtask

    task automatic eval_at(input logic [17:0] px, input logic [17:0] ax,
                           input logic [17:0] py, input logic [17:0] ay,
                           input logic [17:0] tz);
        send_item(FUNC_EVAL, 7'($urandom), $urandom, px, ax, py, ay, tz);
    endtask

    // One APB write: setup cycle, then access cycle. Only called while the
    // block is idle and the input channel is quiet.
    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        i_s_tvalid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every predicted result has come back, then leaves room for
    // a load still in the pipeline.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_caps(input logic [2:0] c0, input logic [2:0] c1, input logic [2:0] c2,
                            input logic [2:0] c3, input logic [2:0] c4);
        drain();
        // Upper bits of the write data are random; only the low three count.
        write_reg(REG_CAP_XF,  {$urandom} & 32'hffff_fff8 | c0);
        write_reg(REG_CAP_XPF, {$urandom} & 32'hffff_fff8 | c1);
        write_reg(REG_CAP_YF,  {$urandom} & 32'hffff_fff8 | c2);
        write_reg(REG_CAP_YPF, {$urandom} & 32'hffff_fff8 | c3);
        write_reg(REG_CAP_ZT,  {$urandom} & 32'hffff_fff8 | c4);
    endtask

    function automatic logic [17:0] rand_x();
        case ($urandom_range(7))
            0: return X_MAX;
            1: return X_MIN;
            2: return 18'd0;
            3: return 18'h10000;
            default: return 18'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    // Random traffic for one phase. Most items are loads that keep changing the
    // table, some of them out of range; the rest are evaluations with random inputs.
    task automatic random_phase(input int items);
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(99) < 35)
                eval_at(rand_x(), rand_x(), rand_x(), rand_x(), rand_x());
            else
                load_coef(7'($urandom_range(127)), rand_coef());
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= FUNC_LOAD;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        hold_req   <= 1'b0;
        sender_idle_pct   = 30;
        receiver_idle_pct = 64;
        loads_sent = 0;
        evals_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every entry is written before the first evaluation, since an
        // unwritten entry holds no defined value.
        for (int i = 0; i < DEPTH; i++) load_coef(7'(i), rand_coef());

        // Directed evaluations at the reset caps: field extremes and zero.
        eval_at(X_MAX, X_MAX, X_MAX, X_MAX, X_MAX);
        eval_at(X_MIN, X_MIN, X_MIN, X_MIN, X_MIN);
        eval_at(18'd0, 18'd0, 18'd0, 18'd0, 18'd0);
        eval_at(X_MAX, X_MIN, 18'd0, X_MAX, X_MIN);
        // Loads beyond the end of the table must be ignored.
        load_coef(7'd126, 32'h7fff_ffff);
        load_coef(7'd127, 32'h8000_0000);
        eval_at(18'h10000, 18'h30000, 18'h10000, 18'h30000, 18'h10000);

        // Large coefficients everywhere drive the accumulator into saturation,
        // first upwards and then, with negative coefficients, downwards.
        for (int i = 0; i < DEPTH; i++) load_coef(7'(i), 32'h7fff_ffff);
        eval_at(X_MAX, X_MAX, X_MAX, X_MAX, X_MAX);
        eval_at(X_MIN, X_MIN, X_MIN, X_MIN, X_MIN);
        for (int i = 0; i < DEPTH; i++) load_coef(7'(i), 32'h8000_0000);
        eval_at(X_MAX, X_MAX, X_MAX, X_MAX, X_MAX);

        // Cap extremes: all zero leaves only the constant term, seven is
        // taken literally, and a write past the last register does nothing.
        set_caps(3'd0, 3'd0, 3'd0, 3'd0, 3'd0);
        eval_at(X_MAX, X_MIN, X_MAX, X_MIN, X_MAX);
        set_caps(3'd7, 3'd7, 3'd7, 3'd7, 3'd7);
        write_reg(3'd5, 32'h0);
        write_reg(3'd7, 32'h0);
        eval_at(X_MIN, X_MAX, X_MIN, X_MAX, X_MIN);

        // Random part: three idling patterns, each over several cap settings.
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    sender_idle_pct = 30;
                    receiver_idle_pct = 64;
                end
                1: begin
                    sender_idle_pct = 64;
                    receiver_idle_pct = 30;
                end
                default: begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int setting = 0; setting < 4; setting++) begin
                if (setting == 0)
                    set_caps(CAP_RST, CAP_RST, CAP_RST, CAP_RST, CAP_RST);
                else
                    set_caps(3'($urandom_range(7)), 3'($urandom_range(7)),
                             3'($urandom_range(7)), 3'($urandom_range(7)),
                             3'($urandom_range(7)));
                // A long receiver hold-off while the sender keeps going, so
                // that the output register fills and the input stalls.
                if (mode == 0 && setting == 1) hold_req <= 1'b1;
                random_phase(20);
            end
        end

        drain();
        repeat (50) @(posedge i_clk);

        $display("Sent %0d loads and %0d evaluations; %0d results checked, %0d saturated.",
                 loads_sent, evals_sent, results, saturations);
        if (errors == 0) begin
            $display("poly5_optics_matrix_eval_test: clean");
        end else begin
            $display("poly5_optics_matrix_eval_test: errors");
        end
        $finish;
    end

endmodule
